/* design/assert_macros.svh */
// Assertion macros for the design; the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PSD_ASSERT_IMPL(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PSD_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define PSD_ASSERT_IMPL(lbl, a, b, msg)
`define PSD_ASSERT_NEXT(lbl, a, b, msg)
`endif
`endif

/* design/psd_pkg.sv */
// Types, constants and register codes of the servo compare mapper.
`timescale 1ns / 1ps

package psd_pkg;

    localparam int CHANNELS  = 4;
    localparam int CH_W      = 2;
    localparam int SAMPLE_W  = 12;
    localparam int CMP_W     = 9;
    localparam int NUM_W     = 24;
    localparam int DIV_STEPS = 12;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [STEP_W-1:0]   LAST_STEP  = STEP_W'(DIV_STEPS - 1);
    localparam logic [CH_W-1:0]     LAST_CH    = CH_W'(CHANNELS - 1);

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [SAMPLE_W-1:0] WIN_LO     = 12'd845;
    localparam logic [SAMPLE_W-1:0] WIN_HI     = 12'd3249;
    localparam logic [SAMPLE_W-1:0] WIN_SPAN   = 12'd2404;
    localparam logic [CMP_W-1:0]    CMP_LO     = 9'd199;
    localparam logic [CMP_W-1:0]    CMP_HI     = 9'd459;
    localparam logic [CMP_W-1:0]    CMP_SPAN   = 9'd260;

    // Multiplying by MAP_RECIP and dropping MAP_SHIFT bits gives x * 260 / 2404
    // exactly for every offset inside the window.
    localparam int                  RECIP_W    = 25;
    localparam int                  MAP_SHIFT  = 28;
    localparam int                  MAP_PROD_W = SAMPLE_W + RECIP_W;
    localparam logic [RECIP_W-1:0]  MAP_RECIP  = 25'd29032185;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELBOW_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRIST_LOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRIP_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd4;

    localparam logic [SAMPLE_W-1:0] BASE_LOW_RST  = 12'd655;
    localparam logic [SAMPLE_W-1:0] ELBOW_LOW_RST = 12'd0;
    localparam logic [SAMPLE_W-1:0] WRIST_LOW_RST = 12'd0;
    localparam logic [SAMPLE_W-1:0] GRIP_LOW_RST  = 12'd1005;
    localparam logic [CMP_W-1:0]    DEADBAND_RST  = 9'd20;

    typedef struct packed {
        logic [SAMPLE_W-1:0] base_sample;
        logic [SAMPLE_W-1:0] elbow_sample;
        logic [SAMPLE_W-1:0] wrist_sample;
        logic [SAMPLE_W-1:0] grip_sample;
    } sample_set_t;

    typedef struct packed {
        logic [CMP_W-1:0] base_compare;
        logic [CMP_W-1:0] elbow_compare;
        logic [CMP_W-1:0] wrist_compare;
        logic [CMP_W-1:0] grip_compare;
        logic             base_written;
        logic             elbow_written;
        logic             wrist_written;
        logic             grip_written;
    } servo_result_t;

    typedef struct packed {
        logic            in_load;
        logic            scale_load;
        logic            map_load;
        logic            div_step;
        logic            commit;
        logic            out_load;
        logic [CH_W-1:0] ch;
    } psd_cmd_t;

    typedef struct packed {
        logic out_free;
    } psd_status_t;

endpackage

/* design/pot_to_servo_pwm_deadband.sv */
// Top level of the potentiometer to servo compare mapper with deadband.
//
//   channel   signals                                        direction
//   sample    sample_valid / sample_ready / sample_set       in
//   result    result_valid / result_ready / servo_result     out
//   config    cfg_valid / cfg_ready / cfg_index / cfg_data   in
//
// Once the input register takes a sample set, each channel in turn passes through a scale
// load, 12 steps of the shared restoring divider, a map load that multiplies by a
// reciprocal and one update; the output load follows the last channel. The next sample
// set is taken only after that output load, when the block is idle again.
// Reset restores the default limits and deadband and clears the held compares.
// A finished result waits in its output register; the next sample set is taken
// meanwhile, and only its own output load stalls until the previous result is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pot_to_servo_pwm_deadband (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  psd_pkg::sample_set_t            sample_set,
    output logic                            result_valid,
    input  logic                            result_ready,
    output psd_pkg::servo_result_t          servo_result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psd_pkg::SAMPLE_W-1:0]    cfg_data
);

    psd_pkg::psd_cmd_t    cmd;
    psd_pkg::psd_status_t status;
    logic                 sample_take;
    logic [5:0]           cmd_bits;

    assign cfg_ready   = 1'b1;
    assign sample_take = sample_valid && sample_ready;
    assign cmd_bits    = {cmd.in_load, cmd.scale_load, cmd.map_load,
                          cmd.div_step, cmd.commit, cmd.out_load};

    psd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    psd_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_set   (sample_set),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .servo_result (servo_result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // The block is busy for the whole computation after an input transfer.
    `PSD_ASSERT_NEXT(a_busy_after_take, sample_take, !sample_ready, "ready after transfer")
    // A result is never loaded over one that has not been taken.
    `PSD_ASSERT_IMPL(a_no_overwrite, cmd.out_load, status.out_free, "result overwritten")
    // The sequencer issues at most one command per cycle.
    `PSD_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0(cmd_bits), "overlapping commands")

endmodule

/* design/psd_ctrl.sv */
// Sequencer that walks the four channels through scaling, mapping and update.
`timescale 1ns / 1ps

module psd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  psd_pkg::psd_status_t status,
    output psd_pkg::psd_cmd_t   cmd
);

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_SCALE_LOAD = 6'b000010,
        ST_SCALE_DIV  = 6'b000100,
        ST_MAP_LOAD   = 6'b001000,
        ST_COMMIT     = 6'b010000,
        ST_DONE       = 6'b100000
    } state_t;

    state_t                        state_reg, state_next;
    logic [psd_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [psd_pkg::CH_W-1:0]      ch_reg, ch_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        ch_next        = ch_reg;
        cmd            = '0;
        cmd.ch         = ch_reg;
        sample_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.in_load = 1'b1;
                    ch_next     = '0;
                    state_next  = ST_SCALE_LOAD;
                end
            end
            ST_SCALE_LOAD:
            begin
                cmd.scale_load = 1'b1;
                step_next      = '0;
                state_next     = ST_SCALE_DIV;
            end
            ST_SCALE_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == psd_pkg::LAST_STEP)
                begin
                    state_next = ST_MAP_LOAD;
                end
            end
            ST_MAP_LOAD:
            begin
                cmd.map_load = 1'b1;
                state_next   = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (ch_reg == psd_pkg::LAST_CH)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_SCALE_LOAD;
                end
            end
            ST_DONE:
            begin
                // Wait until the output register can take the new result.
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

/* design/psd_dpath.sv */
// Datapath: configuration, shared restoring divider, held compares and output register.
`timescale 1ns / 1ps

module psd_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  psd_pkg::psd_cmd_t                   cmd,
    output psd_pkg::psd_status_t                status,
    input  psd_pkg::sample_set_t                sample_set,
    input  logic                                cfg_valid,
    input  logic [psd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psd_pkg::SAMPLE_W-1:0]        cfg_data,
    output psd_pkg::servo_result_t              servo_result,
    output logic                                result_valid,
    input  logic                                result_ready
);

    localparam int SW = psd_pkg::SAMPLE_W;
    localparam int CW = psd_pkg::CMP_W;
    localparam int NW = psd_pkg::NUM_W;
    localparam int PW = psd_pkg::MAP_PROD_W;

    logic [SW-1:0]  low_reg [psd_pkg::CHANNELS];
    logic [CW-1:0]  deadband_reg;
    logic [CW-1:0]  last_reg [psd_pkg::CHANNELS];
    logic [psd_pkg::CHANNELS-1:0] wr_reg;

    psd_pkg::sample_set_t   in_reg;
    psd_pkg::servo_result_t out_reg;
    logic                   out_valid_reg;

    // Divider registers: remainder, shifted divisor and quotient.
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] den_reg, den_next;
    logic [SW-1:0] quo_reg, quo_next;

    logic sc_zero_reg, sc_full_reg;
    logic mp_lo_reg, mp_hi_reg;

    logic [SW-1:0] samp;
    logic [SW-1:0] low;
    logic [SW-1:0] scaled;
    logic [SW-1:0] sdiff;
    logic [SW-1:0] vdiff;
    logic [PW-1:0] map_prod;
    logic [CW-1:0] cmp_new;
    logic [CW-1:0] cmp_old;
    logic [CW-1:0] cmp_diff;
    logic          do_write;

    always_comb
    begin
        case (cmd.ch)
            2'd0:    samp = in_reg.base_sample;
            2'd1:    samp = in_reg.elbow_sample;
            2'd2:    samp = in_reg.wrist_sample;
            default: samp = in_reg.grip_sample;
        endcase
    end

    assign low    = low_reg[cmd.ch];
    assign sdiff  = samp - low;
    assign scaled = sc_zero_reg ? '0 : (sc_full_reg ? psd_pkg::FULL_SCALE : quo_reg);
    assign vdiff  = scaled - psd_pkg::WIN_LO;

    // The window division by a constant is a multiply by its scaled reciprocal.
    assign map_prod = PW'(vdiff) * PW'(psd_pkg::MAP_RECIP);

    assign cmp_new = mp_lo_reg ? psd_pkg::CMP_LO
                   : (mp_hi_reg ? psd_pkg::CMP_HI : psd_pkg::CMP_LO + quo_reg[CW-1:0]);
    assign cmp_old  = last_reg[cmd.ch];
    assign cmp_diff = (cmp_new > cmp_old) ? cmp_new - cmp_old : cmp_old - cmp_new;
    assign do_write = cmp_diff > deadband_reg;

    always_comb
    begin
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        if (cmd.scale_load)
        begin
            // The quotient is below 4096, so the divisor starts at bit 11.
            rem_next = NW'(sdiff) * NW'(psd_pkg::FULL_SCALE);
            den_next = {1'b0, ~low, 11'b0};
            quo_next = '0;
        end
        else if (cmd.map_load)
        begin
            quo_next = SW'(map_prod[PW-1:psd_pkg::MAP_SHIFT]);
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= den_reg)
            begin
                rem_next = rem_reg - den_reg;
                quo_next = {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[SW-2:0], 1'b0};
            end
            den_next = den_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        if (cmd.in_load)
        begin
            in_reg <= sample_set;
        end
        if (cmd.scale_load)
        begin
            sc_zero_reg <= samp <= low;
            sc_full_reg <= samp == psd_pkg::FULL_SCALE;
        end
        if (cmd.map_load)
        begin
            mp_lo_reg <= scaled <= psd_pkg::WIN_LO;
            mp_hi_reg <= scaled >= psd_pkg::WIN_HI;
        end
        if (cmd.commit)
        begin
            wr_reg[cmd.ch] <= do_write;
        end
        if (cmd.out_load)
        begin
            out_reg.base_compare  <= last_reg[0];
            out_reg.elbow_compare <= last_reg[1];
            out_reg.wrist_compare <= last_reg[2];
            out_reg.grip_compare  <= last_reg[3];
            out_reg.base_written  <= wr_reg[0];
            out_reg.elbow_written <= wr_reg[1];
            out_reg.wrist_written <= wr_reg[2];
            out_reg.grip_written  <= wr_reg[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg[0]    <= psd_pkg::BASE_LOW_RST;
            low_reg[1]    <= psd_pkg::ELBOW_LOW_RST;
            low_reg[2]    <= psd_pkg::WRIST_LOW_RST;
            low_reg[3]    <= psd_pkg::GRIP_LOW_RST;
            deadband_reg  <= psd_pkg::DEADBAND_RST;
            for (int i = 0; i < psd_pkg::CHANNELS; i++)
            begin
                last_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    psd_pkg::REG_BASE_LOW:  low_reg[0]   <= cfg_data;
                    psd_pkg::REG_ELBOW_LOW: low_reg[1]   <= cfg_data;
                    psd_pkg::REG_WRIST_LOW: low_reg[2]   <= cfg_data;
                    psd_pkg::REG_GRIP_LOW:  low_reg[3]   <= cfg_data;
                    psd_pkg::REG_DEADBAND:  deadband_reg <= cfg_data[CW-1:0];
                    default:                ;
                endcase
            end
            if (cmd.commit && do_write)
            begin
                last_reg[cmd.ch] <= cmp_new;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || result_ready;
    assign servo_result    = out_reg;
    assign result_valid    = out_valid_reg;

endmodule

/* test/servo_compare_checker.sv */
// Watches the sample, config and result channels of the servo compare mapper and checks each result.
`timescale 1ns / 1ps

module servo_compare_checker
    import psd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    input  logic                 sample_ready,
    input  sample_set_t          sample_set,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  servo_result_t        servo_result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    output int                   mismatches,
    output int                   pending
);

    logic [SAMPLE_W-1:0] low_limit [CHANNELS];
    logic [CMP_W-1:0]    deadband;
    logic [CMP_W-1:0]    held_compare [CHANNELS];
    servo_result_t       due_results [$];

    initial
    begin
        mismatches = 0;
    end

    // Rescale one raw sample against its low limit, then map it onto the servo window.
    function automatic logic [CMP_W-1:0] compare_for(input logic [SAMPLE_W-1:0] raw,
                                                     input logic [SAMPLE_W-1:0] low);
        int unsigned r;
        int unsigned l;
        int unsigned full;
        int unsigned scaled;
        r      = raw;
        l      = low;
        full   = FULL_SCALE;
        if (r <= l)
            scaled = 0;
        else if (r >= full)
            scaled = full;
        else
            scaled = ((r - l) * full) / (full - l);
        if (scaled <= WIN_LO)
            return CMP_LO;
        if (scaled >= WIN_HI)
            return CMP_HI;
        return CMP_W'(CMP_LO + ((scaled - WIN_LO) * CMP_SPAN) / WIN_SPAN);
    endfunction

    task automatic advance_servos(input sample_set_t s, output servo_result_t r);
        logic [SAMPLE_W-1:0] raw [CHANNELS];
        logic [CMP_W-1:0]    target;
        logic [CMP_W-1:0]    change;
        logic                written [CHANNELS];
        raw[0] = s.base_sample;
        raw[1] = s.elbow_sample;
        raw[2] = s.wrist_sample;
        raw[3] = s.grip_sample;
        for (int i = 0; i < CHANNELS; i++)
        begin
            target     = compare_for(raw[i], low_limit[i]);
            change     = (target > held_compare[i]) ? target - held_compare[i]
                                                    : held_compare[i] - target;
            written[i] = change > deadband;
            if (written[i])
                held_compare[i] = target;
        end
        r.base_compare  = held_compare[0];
        r.elbow_compare = held_compare[1];
        r.wrist_compare = held_compare[2];
        r.grip_compare  = held_compare[3];
        r.base_written  = written[0];
        r.elbow_written = written[1];
        r.wrist_written = written[2];
        r.grip_written  = written[3];
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        servo_result_t want;
        servo_result_t fresh;
        if (!rst_n)
        begin
            low_limit[0] = BASE_LOW_RST;
            low_limit[1] = ELBOW_LOW_RST;
            low_limit[2] = WRIST_LOW_RST;
            low_limit[3] = GRIP_LOW_RST;
            deadband     = DEADBAND_RST;
            held_compare = '{default: '0};
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result transfer with no sample set outstanding");
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("base_compare", want.base_compare, servo_result.base_compare);
                    check_field("elbow_compare", want.elbow_compare,
                                servo_result.elbow_compare);
                    check_field("wrist_compare", want.wrist_compare,
                                servo_result.wrist_compare);
                    check_field("grip_compare", want.grip_compare, servo_result.grip_compare);
                    check_field("base_written", want.base_written, servo_result.base_written);
                    check_field("elbow_written", want.elbow_written,
                                servo_result.elbow_written);
                    check_field("wrist_written", want.wrist_written,
                                servo_result.wrist_written);
                    check_field("grip_written", want.grip_written, servo_result.grip_written);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BASE_LOW:  low_limit[0] = cfg_data;
                    REG_ELBOW_LOW: low_limit[1] = cfg_data;
                    REG_WRIST_LOW: low_limit[2] = cfg_data;
                    REG_GRIP_LOW:  low_limit[3] = cfg_data;
                    REG_DEADBAND:  deadband     = cfg_data[CMP_W-1:0];
                    default:       ;
                endcase
            end
            if (sample_valid && sample_ready)
            begin
                advance_servos(sample_set, fresh);
                due_results.push_back(fresh);
            end
            pending <= due_results.size();
        end
    end

endmodule

/* test/pot_to_servo_pwm_deadband_tb.sv */
// Testbench top for the servo compare mapper: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module pot_to_servo_pwm_deadband_tb;
    import psd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_CYCLES = 120;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 150;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    sample_set_t          sample_set   = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    servo_result_t        servo_result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [SAMPLE_W-1:0]  cfg_data     = '0;

    int                   mismatches;
    int                   pending;
    int                   cycle_count  = 0;
    bit                   calm         = 1'b0;
    bit                   long_hold_req = 1'b0;
    logic [SAMPLE_W-1:0]  cur_low  [CHANNELS];
    logic [SAMPLE_W-1:0]  last_raw [CHANNELS];

    pot_to_servo_pwm_deadband i_dut (.*);

    servo_compare_checker i_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Result side: random stalls, plus one long hold-off on request so the block backs up.
    initial
    begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                stall_left = calm ? 0 : idle_gap();
                result_ready <= (stall_left == 0);
            end
        end
    end

    function automatic sample_set_t sample_set_of(input logic [SAMPLE_W-1:0] b,
                                                  input logic [SAMPLE_W-1:0] e,
                                                  input logic [SAMPLE_W-1:0] w,
                                                  input logic [SAMPLE_W-1:0] g);
        sample_set_t s;
        s.base_sample  = b;
        s.elbow_sample = e;
        s.wrist_sample = w;
        s.grip_sample  = g;
        return s;
    endfunction

    // Random walk per channel, with jumps to random values, to the rails and to the region around the low limit.
    function automatic logic [SAMPLE_W-1:0] next_raw(input int ch);
        int unsigned r;
        int          v;
        r = $urandom_range(0, 9);
        if (r < 2)
            v = $urandom_range(0, 4095);
        else if (r == 2)
            v = $urandom_range(0, 1) ? 4095 : 0;
        else if (r == 3)
            v = int'(cur_low[ch]) + int'($urandom_range(0, 8)) - 4;
        else
            v = int'(last_raw[ch]) + int'($urandom_range(0, 160)) - 80;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        last_raw[ch] = SAMPLE_W'(v);
        return last_raw[ch];
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_low();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 4095;
        if (r == 2)
            return 4094;
        return $urandom_range(0, 4095);
    endfunction

    // Upper data bits beyond the deadband width are sometimes set; the block drops them.
    function automatic logic [SAMPLE_W-1:0] pick_deadband();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 460;
        if (r == 2)
            return $urandom_range(0, 4095);
        return $urandom_range(0, 40);
    endfunction

    task automatic send_set(input sample_set_t s);
        int unsigned gap;
        gap = calm ? 0 : idle_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_set   <= s;
        sample_valid <= 1'b1;
        do @(posedge clk); while (!sample_ready);
    endtask

    // Stop offering and wait until every outstanding result has been taken.
    task automatic drain_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_config(input logic [SAMPLE_W-1:0] b, input logic [SAMPLE_W-1:0] e,
                               input logic [SAMPLE_W-1:0] w, input logic [SAMPLE_W-1:0] g,
                               input logic [SAMPLE_W-1:0] db);
        drain_results();
        write_reg(REG_BASE_LOW, b);
        write_reg(REG_ELBOW_LOW, e);
        write_reg(REG_WRIST_LOW, w);
        write_reg(REG_GRIP_LOW, g);
        write_reg(REG_DEADBAND, db);
        // An index past the register file must leave everything as it was.
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_DEADBAND) + 1, 2**CFG_IDX_W - 1)),
                  SAMPLE_W'($urandom));
        cfg_valid <= 1'b0;
        cur_low[0] = b;
        cur_low[1] = e;
        cur_low[2] = w;
        cur_low[3] = g;
    endtask

    initial
    begin : stimulus
        cur_low[0] = BASE_LOW_RST;
        cur_low[1] = ELBOW_LOW_RST;
        cur_low[2] = WRIST_LOW_RST;
        cur_low[3] = GRIP_LOW_RST;
        last_raw   = '{default: 12'd2048};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default limits and deadband; the first set writes all four channels.
        send_set(sample_set_of(0, 0, 0, 0));
        send_set(sample_set_of(4095, 4095, 4095, 4095));
        send_set(sample_set_of(655, 0, 0, 1005));
        send_set(sample_set_of(656, 1, 1, 1006));
        send_set(sample_set_of(4094, 4094, 4094, 4094));
        send_set(sample_set_of(0, 845, 845, 0));
        // Elbow moves by exactly the deadband, then by one more.
        send_set(sample_set_of(0, 1030, 846, 0));
        send_set(sample_set_of(0, 1040, 3248, 0));
        send_set(sample_set_of(0, 1040, 3249, 0));
        send_set(sample_set_of(12'hAAA, 12'h555, 12'hAAA, 12'h555));
        send_set(sample_set_of(12'h555, 12'hAAA, 12'h555, 12'hAAA));

        // Low limit at full scale pins a channel to the bottom; zero deadband writes any change.
        load_config(4095, 4095, 0, 0, 0);
        send_set(sample_set_of(4095, 4095, 2000, 2001));
        send_set(sample_set_of(4095, 0, 2001, 2000));
        send_set(sample_set_of(0, 4095, 2001, 2001));

        // A deadband of 460 or more freezes every channel.
        load_config(0, 0, 4094, 1, 460);
        send_set(sample_set_of(0, 4095, 4095, 0));
        send_set(sample_set_of(4095, 0, 0, 4095));
        load_config(1, 4094, 2048, 4095, 12'hFFF);
        send_set(sample_set_of(1234, 2345, 3456, 100));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                load_config(0, 0, 0, 0, 0);
            else
                load_config(pick_low(), pick_low(), pick_low(), pick_low(), pick_deadband());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if ((phase == 2 || phase == 5) && n == 20)
                    long_hold_req = 1'b1;
                if (phase % 2 == 1 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_set(sample_set_of(next_raw(0), next_raw(1), next_raw(2), next_raw(3)));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/psd_pkg.sv
design/psd_ctrl.sv
design/psd_dpath.sv
design/pot_to_servo_pwm_deadband.sv
test/servo_compare_checker.sv
test/pot_to_servo_pwm_deadband_tb.sv
